### sv/deq_pkg.sv
// deq_pkg: shared constants, operation and status codes, transfer structs
// for the double-ended queue; depends on nothing
package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int VAL_W      = 32;
    localparam int OCC_W      = 5;

    typedef enum logic [1:0] {
        OP_INS_REAR  = 2'd0,
        OP_INS_FRONT = 2'd1,
        OP_REM_FRONT = 2'd2,
        OP_REM_REAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_op                     op;
        logic signed [VAL_W-1:0] value_in;
    } t_deq_req;

    typedef struct packed {
        logic signed [VAL_W-1:0] value_out;
        t_status                 status;
        logic [OCC_W-1:0]        occupancy;
    } t_deq_rsp;

    // decision for one accepted request, from pointer logic to the top
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        t_status           status;
        logic [CNT_W-1:0]  count_next;
    } t_deq_plan;

    // keep the low DATA_WIDTH bits of a value
    function automatic logic [DATA_WIDTH-1:0] to_store(input logic [VAL_W-1:0] v);
        return DATA_WIDTH'(v);
    endfunction

    // sign-extend a stored entry back to the result width
    function automatic logic [VAL_W-1:0] from_store(input logic [DATA_WIDTH-1:0] d);
        return VAL_W'(signed'(d));
    endfunction

endpackage

### sv/deq_ram.sv
// deq_ram: single-port synchronous RAM with registered read data
// generic, no package dependency
module deq_ram #(
    parameter int ADDR_W = 4,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/deq_ptrs.sv
// deq_ptrs: head and tail indices and entry count of the ring store,
// picks the entry address and status per request; uses deq_pkg
module deq_ptrs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  deq_pkg::t_op       i_op,
    output deq_pkg::t_deq_plan o_plan
);

    logic [deq_pkg::ADDR_W-1:0] r_head, n_head;
    logic [deq_pkg::ADDR_W-1:0] r_tail, n_tail;
    logic [deq_pkg::CNT_W-1:0]  r_count;
    logic [deq_pkg::ADDR_W-1:0] head_dn, tail_dn;
    logic                       full, empty;

    function automatic logic [deq_pkg::ADDR_W-1:0] step_up(
        input logic [deq_pkg::ADDR_W-1:0] i
    );
        return (i == deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [deq_pkg::ADDR_W-1:0] step_down(
        input logic [deq_pkg::ADDR_W-1:0] i
    );
        return (i == '0) ? deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1) : i - 1'b1;
    endfunction

    assign head_dn = step_down(r_head);
    assign tail_dn = step_down(r_tail);
    assign full    = (r_count == deq_pkg::CNT_W'(deq_pkg::DEPTH));
    assign empty   = (r_count == '0);

    always_comb begin
        o_plan            = '0;
        o_plan.status     = deq_pkg::ST_OK;
        o_plan.count_next = r_count;
        n_head            = r_head;
        n_tail            = r_tail;
        unique case (i_op)
            deq_pkg::OP_INS_REAR: begin
                o_plan.addr = r_tail;
                if (full) begin
                    o_plan.status = deq_pkg::ST_FULL;
                end else begin
                    o_plan.wr_en      = 1'b1;
                    o_plan.count_next = r_count + 1'b1;
                    n_tail            = step_up(r_tail);
                end
            end
            deq_pkg::OP_INS_FRONT: begin
                o_plan.addr = head_dn;
                if (full) begin
                    o_plan.status = deq_pkg::ST_FULL;
                end else begin
                    o_plan.wr_en      = 1'b1;
                    o_plan.count_next = r_count + 1'b1;
                    n_head            = head_dn;
                end
            end
            deq_pkg::OP_REM_FRONT: begin
                o_plan.addr = r_head;
                if (empty) begin
                    o_plan.status = deq_pkg::ST_EMPTY;
                end else begin
                    o_plan.rd_en      = 1'b1;
                    o_plan.count_next = r_count - 1'b1;
                    n_head            = step_up(r_head);
                end
            end
            deq_pkg::OP_REM_REAR: begin
                o_plan.addr = tail_dn;
                if (empty) begin
                    o_plan.status = deq_pkg::ST_EMPTY;
                end else begin
                    o_plan.rd_en      = 1'b1;
                    o_plan.count_next = r_count - 1'b1;
                    n_tail            = tail_dn;
                end
            end
            default: begin
                o_plan.addr = r_head;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= o_plan.count_next;
        end
    end

endmodule

### sv/double_ended_queue.sv
// double_ended_queue: bounded deque over a ring store in one synchronous RAM
// insertions and empty removals register their result at the transfer edge;
// removals that read the RAM register it after the RAM read, from state S_READ
// throughput: 1 request per cycle for insertions and empty removals; a removal
// that reads the RAM holds busy until its result; reset empties the queue, RAM kept
// results are strobed for one cycle; the receiver cannot stall them
module double_ended_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  deq_pkg::t_deq_req i_req,
    output logic              busy,
    output logic              o_valid,
    output deq_pkg::t_deq_rsp o_rsp
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state                      r_state;
    logic                        r_valid;
    deq_pkg::t_deq_rsp           r_rsp;
    logic [deq_pkg::OCC_W-1:0]   r_occ_hold;   // occupancy kept across the ram read

    logic                        accept;
    deq_pkg::t_deq_plan          plan;
    logic [deq_pkg::DATA_WIDTH-1:0] rd_data;

    // a transfer happens only while no ram read is pending
    assign busy   = (r_state == S_READ);
    assign accept = start && !busy;

    // pointer and count bookkeeping, one decision per transfer
    deq_ptrs u_ptrs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_op     (i_req.op),
        .o_plan   (plan)
    );

    // entry store; an insert writes at the transfer edge, a removal reads at
    // its own transfer edge, so a write always lands before any later read
    deq_ram #(
        .ADDR_W (deq_pkg::ADDR_W),
        .DATA_W (deq_pkg::DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept && plan.wr_en),
        .i_re    (accept && plan.rd_en),
        .i_addr  (plan.addr),
        .i_wdata (deq_pkg::to_store(i_req.value_in)),
        .o_rdata (rd_data)
    );

    // state and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (plan.rd_en) begin
                            // wait in S_READ for the ram data
                            r_state    <= S_READ;
                            r_occ_hold <= deq_pkg::OCC_W'(plan.count_next);
                        end else begin
                            // insert, full insert or empty removal
                            r_valid           <= 1'b1;
                            r_rsp.status      <= plan.status;
                            r_rsp.occupancy   <= deq_pkg::OCC_W'(plan.count_next);
                            r_rsp.value_out   <= (plan.status == deq_pkg::ST_EMPTY) ?
                                                 '1 : '0;
                        end
                    end
                end
                S_READ: begin
                    r_state         <= S_IDLE;
                    r_valid         <= 1'b1;
                    r_rsp.status    <= deq_pkg::ST_OK;
                    r_rsp.occupancy <= r_occ_hold;
                    r_rsp.value_out <= deq_pkg::from_store(rd_data);
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

`ifndef NO_ASSERTIONS
    // every transfer yields a result next cycle or starts a ram read
    a_transfer_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (o_valid || busy))
        else $error("transfer neither produced a result nor started a read");

    // the read state is only entered from a transfer
    a_busy_from_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> ($past(accept) && !$past(busy)))
        else $error("busy without a preceding removal transfer");

    // a read always ends in a successful result
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_valid && (o_rsp.status == deq_pkg::ST_OK)))
        else $error("ram read did not produce an ok result");

    // occupancy never exceeds the store
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.occupancy <= deq_pkg::OCC_W'(deq_pkg::DEPTH)))
        else $error("occupancy beyond depth");
`endif

endmodule
